@@ rtl/sqs_pkg.sv @@
// Package for the shortest queue selector: payload structs, command and
// register codes, the sequencer state type and default sizes.
// No dependencies.
package sqs_pkg;

   // Default sizes handed to the top level parameters.
   localparam int MAX_LINES_DEF    = 128;
   localparam int LENGTH_WIDTH_DEF = 16;

   // Configuration port sizes.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register index of the active line count.
   localparam logic REG_ACTIVE_LINES = 1'b0;

   // Reset value of the active line count.
   localparam logic [7:0] ACTIVE_LINES_RST = 8'd128;

   // Item commands.
   typedef enum logic {
      CMD_LOAD   = 1'b0,
      CMD_ARRIVE = 1'b1
   } cmd_type;

   // Input item.
   typedef struct packed {
      cmd_type     cmd;
      logic [6:0]  line_index;
      logic [15:0] line_length;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [6:0]  joined_line;
      logic [15:0] people_ahead;
      logic        saturated;
   } rsp_type;

   // Sequencer states for an arrival.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TAIL,
      ST_FINISH
   } state_type;

   // Control from the sequencer to the length table.
   typedef struct packed {
      logic rd_en;
      logic rd_first;
      logic wr_en;
   } tbl_ctrl_type;

endpackage

@@ rtl/sqs_table.sv @@
// Length table of the shortest queue selector: one synchronous memory with
// a registered read port, and the running minimum over the scanned entries.
// Depends on sqs_pkg.
module sqs_table #(
   parameter int MAX_LINES    = sqs_pkg::MAX_LINES_DEF,
   parameter int LENGTH_WIDTH = sqs_pkg::LENGTH_WIDTH_DEF,
   parameter int IDX_W        = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sqs_pkg::tbl_ctrl_type    ctrl,
   input  logic [IDX_W-1:0]         rd_addr,
   input  logic [IDX_W-1:0]         wr_addr,
   input  logic [LENGTH_WIDTH-1:0]  wr_data,
   output logic [IDX_W-1:0]         best_idx,
   output logic [LENGTH_WIDTH-1:0]  best_len
);

   logic [LENGTH_WIDTH-1:0] mem [MAX_LINES];

   logic [LENGTH_WIDTH-1:0] rd_data_ff;
   logic [IDX_W-1:0]        rd_tag_ff;
   logic                    rd_first_ff;
   logic                    rd_vld_ff;
   logic [IDX_W-1:0]        best_idx_ff;
   logic [LENGTH_WIDTH-1:0] best_len_ff;
   logic                    take_new;

   // Memory write port and registered read port.
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      rd_tag_ff   <= rd_addr;
      rd_first_ff <= ctrl.rd_first;
   end

   // Read data is valid in the cycle after the read is issued.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= ctrl.rd_en;
      end
   end

   // The first entry of a scan seeds the minimum; a strictly smaller one
   // replaces it, so the lowest index wins a tie.
   assign take_new = rd_vld_ff && (rd_first_ff || (rd_data_ff < best_len_ff));

   always_ff @(posedge clock) begin
      if (take_new) begin
         best_idx_ff <= rd_tag_ff;
         best_len_ff <= rd_data_ff;
      end
   end

   assign best_idx = best_idx_ff;
   assign best_len = best_len_ff;

endmodule

@@ rtl/shortest_queue_selector_top.sv @@
// Top level of the shortest queue selector: configuration register,
// arrival sequencer, output register and the length table.
// Depends on sqs_pkg and sqs_table.
//
// Usage. Items enter on the req_ channel (valid and stall) and results
// leave on the rsp_ channel. A load item writes one line's starting length
// and gives no result. An arrival item scans the first N entries of the
// length table, where N is the effective active line count, one memory
// read per cycle, picks the shortest line (lowest index on a tie), reports
// its index and length before the join, and writes back the length plus
// one unless it is already at its maximum, in which case the saturated
// flag is set. An arrival is accepted in the idle state; the sequencer
// then scans through the single read port of the table memory, passes
// the tail and finish states, loads the result in the finish state and
// takes no new item until it is back in idle.
// The result sits in an output register; while the receiver stalls it, the
// block still takes load items and starts the next arrival, and holds that
// arrival's write back until the register is free. Reset sets active_lines
// to 128 and idles the sequencer; table entries hold no value until loaded.
module shortest_queue_selector_top #(
   parameter int MAX_LINES    = sqs_pkg::MAX_LINES_DEF,
   parameter int LENGTH_WIDTH = sqs_pkg::LENGTH_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Input channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  sqs_pkg::req_type                 req_data,
   // Result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output sqs_pkg::rsp_type                 rsp_data,
   // Configuration port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sqs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sqs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sqs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   localparam int IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int CNT_W = (IDX_W + 1 > 8) ? IDX_W + 1 : 8;

   sqs_pkg::state_type      state_ff, state_in;
   logic [7:0]              active_lines_ff;
   logic [IDX_W-1:0]        scan_addr_ff, scan_addr_in;
   logic [IDX_W-1:0]        last_ff, last_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   sqs_pkg::rsp_type        rsp_ff, rsp_in;

   logic                    csr_wr;
   logic                    req_accept;
   logic                    is_arrive;
   logic [CNT_W-1:0]        act_ext;
   logic [CNT_W-1:0]        eff_lines;
   logic [CNT_W-1:0]        line_ext;
   logic                    load_ok;
   logic [31:0]             len_ext;
   logic [31:0]             best_ext;
   logic [CNT_W-1:0]        best_idx_ext;
   logic                    out_free;
   logic                    sat;

   sqs_pkg::tbl_ctrl_type   tbl_ctrl;
   logic [IDX_W-1:0]        tbl_rd_addr;
   logic [IDX_W-1:0]        tbl_wr_addr;
   logic [LENGTH_WIDTH-1:0] tbl_wr_data;
   logic [IDX_W-1:0]        best_idx;
   logic [LENGTH_WIDTH-1:0] best_len;

   // Configuration port: the register is written in the access phase.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_lines_ff <= sqs_pkg::ACTIVE_LINES_RST;
      end else if (csr_wr && (csr_paddr[2] == sqs_pkg::REG_ACTIVE_LINES)) begin
         active_lines_ff <= csr_pwdata[7:0];
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         sqs_pkg::REG_ACTIVE_LINES: csr_prdata = 32'(active_lines_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // Effective line count, clamped to one and to the table depth.
   always_comb begin
      act_ext = CNT_W'(active_lines_ff);
      if (act_ext == '0) begin
         eff_lines = CNT_W'(1);
      end else if (act_ext > CNT_W'(MAX_LINES)) begin
         eff_lines = CNT_W'(MAX_LINES);
      end else begin
         eff_lines = act_ext;
      end
   end

   // Input decode.
   assign req_stall  = (state_ff != sqs_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign is_arrive  = (req_data.cmd == sqs_pkg::CMD_ARRIVE);
   assign line_ext   = CNT_W'(req_data.line_index);
   assign load_ok    = (line_ext < CNT_W'(MAX_LINES));
   assign len_ext    = 32'(req_data.line_length);

   // Result fields from the final minimum.
   assign sat          = (best_len == '1);
   assign best_ext     = 32'(best_len);
   assign best_idx_ext = CNT_W'(best_idx);
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   // Sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sqs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      last_ff      <= last_in;
      rsp_ff       <= rsp_in;
   end

   // Sequencer next state, table control and output register.
   always_comb begin
      state_in          = state_ff;
      scan_addr_in      = scan_addr_ff;
      last_in           = last_ff;
      rsp_in            = rsp_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      tbl_ctrl.rd_en    = 1'b0;
      tbl_ctrl.rd_first = 1'b0;
      tbl_ctrl.wr_en    = 1'b0;
      tbl_rd_addr       = scan_addr_ff;
      tbl_wr_addr       = line_ext[IDX_W-1:0];
      tbl_wr_data       = len_ext[LENGTH_WIDTH-1:0];
      unique case (state_ff)
         sqs_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (is_arrive) begin
                  state_in     = sqs_pkg::ST_SCAN;
                  scan_addr_in = '0;
                  last_in      = IDX_W'(eff_lines - CNT_W'(1));
               end else begin
                  tbl_ctrl.wr_en = load_ok;
               end
            end
         end
         sqs_pkg::ST_SCAN: begin
            tbl_ctrl.rd_en    = 1'b1;
            tbl_ctrl.rd_first = (scan_addr_ff == '0);
            if (scan_addr_ff == last_ff) begin
               state_in = sqs_pkg::ST_TAIL;
            end else begin
               scan_addr_in = scan_addr_ff + IDX_W'(1);
            end
         end
         sqs_pkg::ST_TAIL: begin
            state_in = sqs_pkg::ST_FINISH;
         end
         sqs_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in            = sqs_pkg::ST_IDLE;
               tbl_ctrl.wr_en      = !sat;
               tbl_wr_addr         = best_idx;
               tbl_wr_data         = best_len + LENGTH_WIDTH'(1);
               rsp_valid_in        = 1'b1;
               rsp_in.joined_line  = best_idx_ext[6:0];
               rsp_in.people_ahead = best_ext[15:0];
               rsp_in.saturated    = sat;
            end
         end
         default: begin
            state_in = sqs_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   sqs_table #(
      .MAX_LINES    (MAX_LINES),
      .LENGTH_WIDTH (LENGTH_WIDTH),
      .IDX_W        (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (tbl_ctrl),
      .rd_addr  (tbl_rd_addr),
      .wr_addr  (tbl_wr_addr),
      .wr_data  (tbl_wr_data),
      .best_idx (best_idx),
      .best_len (best_len)
   );

   // No table write may land while a scan is reading the table.
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sqs_pkg::ST_SCAN || state_ff == sqs_pkg::ST_TAIL) |-> !tbl_ctrl.wr_en)
      else $error("table write during a scan");

   // The chosen line lies among the scanned lines.
   a_best_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sqs_pkg::ST_FINISH) |-> (best_idx <= last_ff))
      else $error("chosen line outside the active lines");

   // A new result is loaded only when the sequencer finishes an arrival.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == sqs_pkg::ST_FINISH))
      else $error("result without a finished arrival");

   // An accepted arrival starts a scan in the next cycle.
   a_arrive_scans: assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_arrive) |=> (state_ff == sqs_pkg::ST_SCAN))
      else $error("accepted arrival did not start a scan");

endmodule

@@ bench/shortest_queue_selector_top_tb.sv @@
// Self-checking testbench for the shortest queue selector: a directed stimulus
// table, then random phases at several active line counts, all results checked.
// Depends on sqs_pkg and shortest_queue_selector_top.
module shortest_queue_selector_top_tb;

   localparam int N_LINES     = sqs_pkg::MAX_LINES_DEF;
   localparam int SETTLE      = N_LINES + 12;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_ITEMS = 60;
   localparam int N_DIR       = 20;
   localparam int N_PHASES    = 10;
   localparam int REG_UNUSED_INDEX = 1;
   localparam logic [sqs_pkg::CSR_ADDR_W-1:0] ADDR_ACTIVE =
      sqs_pkg::CSR_ADDR_W'(4 * int'(sqs_pkg::REG_ACTIVE_LINES));
   localparam logic [sqs_pkg::CSR_ADDR_W-1:0] ADDR_UNUSED =
      sqs_pkg::CSR_ADDR_W'(4 * REG_UNUSED_INDEX);
   localparam logic [15:0] LEN_MAX = 16'hFFFF;
   localparam sqs_pkg::rsp_type NO_RSP = '0;

   // One row of the directed table: an optional line count to set first,
   // the item, and the result typed in where it is obvious.
   typedef struct packed {
      bit                set_cfg;
      logic [7:0]        cfg;
      sqs_pkg::req_type  item;
      bit                typed;
      sqs_pkg::rsp_type  want;
   } dir_row_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   sqs_pkg::req_type               req_data;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   sqs_pkg::rsp_type               rsp_data;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [sqs_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [sqs_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [sqs_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // Shadow of the block: line lengths, which lines were loaded, line count.
   logic [15:0]      line_len [N_LINES];
   bit               line_loaded [N_LINES];
   logic [7:0]       active_setting = sqs_pkg::ACTIVE_LINES_RST;
   sqs_pkg::rsp_type pending_joins [$];

   int errors = 0;
   int n_loads = 0;
   int n_arrivals = 0;
   int n_checked = 0;
   int n_sat = 0;
   int n_settings = 0;
   int cycles = 0;
   int burst_left = 0;
   int stall_mode = 0;
   int stall_left = 0;
   int hold_left = 0;
   bit hold_val = 1'b0;

   // Directed table. Phase one runs one line (a setting of 0 acts as 1),
   // phase two four lines with ties, phase three two lines.
   dir_row_type dir_rows [N_DIR] = '{
      '{1'b1, 8'd0, '{sqs_pkg::CMD_LOAD,   7'd0,   16'd0},    1'b0, NO_RSP},
      '{1'b0, 8'd0, '{sqs_pkg::CMD_ARRIVE, 7'd0,   16'd0},    1'b1, '{7'd0, 16'd0, 1'b0}},
      '{1'b0, 8'd0, '{sqs_pkg::CMD_ARRIVE, 7'd127, 16'hFFFF}, 1'b1, '{7'd0, 16'd1, 1'b0}},
      '{1'b0, 8'd0, '{sqs_pkg::CMD_LOAD,   7'd127, 16'hFFFF}, 1'b0, NO_RSP},
      '{1'b0, 8'd0, '{sqs_pkg::CMD_LOAD,   7'd0,   16'hFFFE}, 1'b0, NO_RSP},
      '{1'b0, 8'd0, '{sqs_pkg::CMD_ARRIVE, 7'd0,   16'd0},    1'b1, '{7'd0, 16'hFFFE, 1'b0}},
      '{1'b0, 8'd0, '{sqs_pkg::CMD_ARRIVE, 7'd0,   16'd0},    1'b1, '{7'd0, 16'hFFFF, 1'b1}},
      '{1'b0, 8'd0, '{sqs_pkg::CMD_ARRIVE, 7'd0,   16'd0},    1'b1, '{7'd0, 16'hFFFF, 1'b1}},
      '{1'b1, 8'd4, '{sqs_pkg::CMD_LOAD,   7'd1,   16'd3},    1'b0, NO_RSP},
      '{1'b0, 8'd0, '{sqs_pkg::CMD_LOAD,   7'd2,   16'd3},    1'b0, NO_RSP},
      '{1'b0, 8'd0, '{sqs_pkg::CMD_LOAD,   7'd3,   16'd9},    1'b0, NO_RSP},
      '{1'b0, 8'd0, '{sqs_pkg::CMD_ARRIVE, 7'd0,   16'd0},    1'b1, '{7'd1, 16'd3, 1'b0}},
      '{1'b0, 8'd0, '{sqs_pkg::CMD_ARRIVE, 7'd0,   16'd0},    1'b1, '{7'd2, 16'd3, 1'b0}},
      '{1'b0, 8'd0, '{sqs_pkg::CMD_ARRIVE, 7'd0,   16'd0},    1'b0, NO_RSP},
      '{1'b0, 8'd0, '{sqs_pkg::CMD_LOAD,   7'd3,   16'd0},    1'b0, NO_RSP},
      '{1'b0, 8'd0, '{sqs_pkg::CMD_ARRIVE, 7'd85,  16'h5555}, 1'b0, NO_RSP},
      '{1'b1, 8'd2, '{sqs_pkg::CMD_ARRIVE, 7'd42,  16'hAAAA}, 1'b0, NO_RSP},
      '{1'b0, 8'd0, '{sqs_pkg::CMD_LOAD,   7'd1,   16'h5555}, 1'b0, NO_RSP},
      '{1'b0, 8'd0, '{sqs_pkg::CMD_LOAD,   7'd0,   16'hAAAA}, 1'b0, NO_RSP},
      '{1'b0, 8'd0, '{sqs_pkg::CMD_ARRIVE, 7'd0,   16'd0},    1'b0, NO_RSP}
   };

   // Line count settings of the random phases, extremes among them.
   int phase_setting [N_PHASES] = '{3, 1, 128, 16, 0, 6, 255, 40, 2, 0};

   shortest_queue_selector_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycles, pending_joins.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // Number of lines that take part in the search for the current setting.
   function automatic int search_lines();
      int n;
      n = int'(active_setting);
      if (n < 1) n = 1;
      if (n > N_LINES) n = N_LINES;
      return n;
   endfunction

   // Applies one accepted item to the shadow state; returns 1 and the join
   // result for an arrival.
   function automatic bit apply_item(input sqs_pkg::req_type it,
                                     output sqs_pkg::rsp_type res);
      int n;
      int best;
      logic [15:0] best_len;
      res = '0;
      if (it.cmd == sqs_pkg::CMD_LOAD) begin
         line_len[it.line_index] = it.line_length;
         line_loaded[it.line_index] = 1'b1;
         n_loads++;
         return 1'b0;
      end
      n = search_lines();
      best = 0;
      best_len = line_len[0];
      for (int k = 1; k < n; k++) begin
         if (line_len[k] < best_len) begin
            best_len = line_len[k];
            best = k;
         end
      end
      res.joined_line  = 7'(best);
      res.people_ahead = best_len;
      res.saturated    = (best_len == LEN_MAX);
      if (!res.saturated) line_len[best] = best_len + 16'd1;
      n_arrivals++;
      return 1'b1;
   endfunction

   // Lengths biased toward ties near zero and toward saturation.
   function automatic logic [15:0] random_length();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 3));
         1: return LEN_MAX - 16'($urandom_range(0, 2));
         2: return 16'($urandom());
         default: return 16'($urandom_range(0, 300));
      endcase
   endfunction

   // Random item. An arrival with an active line still unloaded becomes a
   // load of that line instead, flagged as preparation.
   function automatic sqs_pkg::req_type random_item(output bit prep);
      sqs_pkg::req_type it;
      int n;
      n = search_lines();
      prep = 1'b0;
      it.line_index  = 7'($urandom());
      it.line_length = 16'($urandom());
      if ($urandom_range(0, 99) < 55) begin
         it.cmd = sqs_pkg::CMD_ARRIVE;
         for (int k = 0; k < n; k++) begin
            if (!line_loaded[k] && !prep) begin
               it = '{sqs_pkg::CMD_LOAD, 7'(k), random_length()};
               prep = 1'b1;
            end
         end
      end else begin
         it.cmd = sqs_pkg::CMD_LOAD;
         it.line_index = $urandom_range(0, 1) ? 7'($urandom_range(0, n - 1))
                                              : 7'($urandom_range(0, N_LINES - 1));
         it.line_length = random_length();
      end
      return it;
   endfunction

   // Presents one item, waits for its handshake and records the expected join.
   task automatic send_item(input sqs_pkg::req_type it, input bit typed,
                            input sqs_pkg::rsp_type want);
      sqs_pkg::rsp_type predicted;
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (apply_item(it, predicted)) pending_joins.push_back(typed ? want : predicted);
   endtask

   // Sender bursts: random length, random gaps, sometimes no gap at all.
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
   endtask

   // Stops sending until every expected join has come back.
   task automatic wait_for_joins();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_joins.size() != 0) @(posedge clock);
   endtask

   // One APB transfer, then the bus returns to idle.
   task automatic csr_xfer(input bit wr, input logic [sqs_pkg::CSR_ADDR_W-1:0] addr,
                           input logic [7:0] val,
                           output logic [sqs_pkg::CSR_DATA_W-1:0] rd);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= {24'($urandom()), val};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rd = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (wr && addr == ADDR_ACTIVE) active_setting = val;
      @(posedge clock);
   endtask

   // Writes a register (upper data bits random) and reads the line count back.
   task automatic write_and_check(input logic [sqs_pkg::CSR_ADDR_W-1:0] addr,
                                  input logic [7:0] val);
      logic [sqs_pkg::CSR_DATA_W-1:0] rd;
      csr_xfer(1'b1, addr, val, rd);
      csr_xfer(1'b0, ADDR_ACTIVE, 8'd0, rd);
      if (rd !== sqs_pkg::CSR_DATA_W'(active_setting)) begin
         $display("%0t: active_lines read expected %0d, got %0d", $time, active_setting, rd);
         errors++;
      end
      if (addr == ADDR_ACTIVE) n_settings++;
   endtask

   // Lets the block go idle before a register write.
   task automatic drain_and_settle();
      wait_for_joins();
      repeat (SETTLE) @(posedge clock);
   endtask

   // Receiver stall pattern: free running, random, or long holds, in turns.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 200);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         default: begin
            if (hold_left == 0) begin
               hold_val  = ~hold_val;
               hold_left = $urandom_range(1, 40);
            end else begin
               hold_left--;
            end
            rsp_stall <= hold_val;
         end
      endcase
   end

   // Result checker: each accepted result against the oldest expected join.
   always @(posedge clock) begin
      sqs_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_joins.size() == 0) begin
            $display("%0t: unexpected result line %0d ahead %0d sat %0b", $time,
                     rsp_data.joined_line, rsp_data.people_ahead, rsp_data.saturated);
            errors++;
         end else begin
            want = pending_joins.pop_front();
            n_checked++;
            if (want.saturated) n_sat++;
            if (rsp_data.joined_line !== want.joined_line
                || rsp_data.people_ahead !== want.people_ahead
                || rsp_data.saturated !== want.saturated) begin
               $display("%0t: join line/ahead/sat expected %0d/%0d/%0b, got %0d/%0d/%0b",
                        $time, want.joined_line, want.people_ahead, want.saturated,
                        rsp_data.joined_line, rsp_data.people_ahead, rsp_data.saturated);
               errors++;
            end
         end
      end
   end

   // Main sequence: reset, register checks, directed table, random phases.
   initial begin
      logic [sqs_pkg::CSR_DATA_W-1:0] rd;
      sqs_pkg::req_type it;
      bit prep;
      int sent;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      for (int k = 0; k < N_LINES; k++) begin
         line_len[k] = '0;
         line_loaded[k] = 1'b0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset value, then a write to an unused register index must not stick.
      csr_xfer(1'b0, ADDR_ACTIVE, 8'd0, rd);
      if (rd !== sqs_pkg::CSR_DATA_W'(sqs_pkg::ACTIVE_LINES_RST)) begin
         $display("%0t: active_lines after reset expected %0d, got %0d",
                  $time, sqs_pkg::ACTIVE_LINES_RST, rd);
         errors++;
      end
      write_and_check(ADDR_UNUSED, 8'd5);

      // Directed table.
      for (int i = 0; i < N_DIR; i++) begin
         if (dir_rows[i].set_cfg) begin
            drain_and_settle();
            write_and_check(ADDR_ACTIVE, dir_rows[i].cfg);
         end
         pace();
         send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      end

      // Random phases; preparation loads do not count toward a phase.
      for (int p = 0; p < N_PHASES; p++) begin
         drain_and_settle();
         write_and_check(ADDR_ACTIVE,
                         (p == N_PHASES - 1) ? 8'($urandom_range(1, 255))
                                             : 8'(phase_setting[p]));
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pace();
            if ($urandom_range(0, 39) == 0) wait_for_joins();
            it = random_item(prep);
            send_item(it, 1'b0, NO_RSP);
            if (!prep) sent++;
         end
      end

      drain_and_settle();
      $display("Covered %0d loads and %0d arrivals over %0d line count settings.",
               n_loads, n_arrivals, n_settings);
      $display("Checked %0d joins, %0d on a full line; %0d errors.",
               n_checked, n_sat, errors);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
